/* hdl/soc_pkg.sv */
package soc_pkg;

	localparam int STORE_DEPTH_DEF = 1024;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 11;
	localparam int IN_TDATA_W = 32;
	localparam int OUT_TDATA_W = 16;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SRCH = 6'b000010,
		ST_SHRD = 6'b000100,
		ST_SHWR = 6'b001000,
		ST_INS  = 6'b010000,
		ST_RES  = 6'b100000
	} state_t;

endpackage

/* hdl/sorted_occurrence_counter.sv */
// channel  dir  tdata                        tuser
// s_*      in   value (32, signed)           kind (1: 0 load, 1 query)
// m_*      out  occurrence_count (11), pad   -
//
// One transaction at a time; s_tready is high only while idle.
// Query: accept, then two binary searches, one probe per step
// (up to ceil(log2(n+1)) probes each over n held entries), then the result.
// Load: accept, one search, a read and a write state per entry moved up (single RAM
// port pair, registered read), then an insert. A load into a full store is dropped.
// Reset empties the store through the fill count; no clearing pass.
// A result waiting on m_tready holds the next one in the result state.
module sorted_occurrence_counter #(
	parameter int STORE_DEPTH = soc_pkg::STORE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic        s_tuser,   // [0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [10:0] occurrence_count, [15:11] zero
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int CW = $clog2(STORE_DEPTH + 1);
	localparam logic [CW-1:0] FULL = CW'(STORE_DEPTH);

	soc_pkg::state_t state_q;
	logic [CW-1:0] count_q;
	logic          m_tvalid_q;

	logic                             kind_q;
	logic signed [soc_pkg::VALUE_W-1:0] key_q;
	logic [CW-1:0] lo_q, hi_q, mid_q, right_q, pos_q, res_q;
	logic          lower_q;
	logic [AW-1:0] j_q;
	logic [soc_pkg::COUNT_W-1:0] m_data_q;

	logic [soc_pkg::VALUE_W-1:0] rdata;
	logic signed [soc_pkg::VALUE_W-1:0] probe;
	logic          go_right, more, accept;
	logic [CW-1:0] nlo, nhi, nmid, half_cnt, half_nlo, cnt_m1;
	logic [AW-1:0] raddr, waddr;
	logic [soc_pkg::VALUE_W-1:0] wdata;
	logic          we;
	logic [31:0]   res_ext;

	assign accept = s_tvalid && s_tready;
	assign s_tready = (state_q == soc_pkg::ST_IDLE);

	// one probe: compare, narrow the range, pick the next midpoint
	assign probe    = $signed(rdata);
	assign go_right = lower_q ? (probe < key_q) : (probe <= key_q);
	assign nlo      = go_right ? mid_q + 1'b1 : lo_q;
	assign nhi      = go_right ? hi_q : mid_q;
	assign more     = nlo < nhi;
	assign nmid     = nlo + ((nhi - nlo) >> 1);
	assign half_cnt = count_q >> 1;
	assign half_nlo = nlo >> 1;
	assign cnt_m1   = count_q - 1'b1;

	always_comb begin
		raddr = '0;
		we    = 1'b0;
		waddr = j_q + 1'b1;
		wdata = rdata;
		case (state_q)
			soc_pkg::ST_IDLE: raddr = half_cnt[AW-1:0];
			soc_pkg::ST_SRCH: raddr = more ? nmid[AW-1:0] : half_nlo[AW-1:0];
			soc_pkg::ST_SHRD: raddr = j_q;
			soc_pkg::ST_SHWR: we = 1'b1;
			soc_pkg::ST_INS: begin
				we    = 1'b1;
				waddr = pos_q[AW-1:0];
				wdata = key_q;
			end
			default: ;
		endcase
	end

	soc_ram #(
		.WIDTH(soc_pkg::VALUE_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= soc_pkg::ST_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == soc_pkg::ST_RES && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				soc_pkg::ST_IDLE: begin
					if (accept) begin
						if (s_tuser == soc_pkg::KIND_LOAD && count_q == FULL) begin
							state_q <= soc_pkg::ST_IDLE;
						end else if (count_q == '0) begin
							state_q <= (s_tuser == soc_pkg::KIND_LOAD) ?
								soc_pkg::ST_INS : soc_pkg::ST_RES;
						end else begin
							state_q <= soc_pkg::ST_SRCH;
						end
					end
				end
				soc_pkg::ST_SRCH: begin
					if (!more) begin
						if (kind_q == soc_pkg::KIND_LOAD) begin
							state_q <= (nlo == count_q) ? soc_pkg::ST_INS : soc_pkg::ST_SHRD;
						end else if (lower_q || nlo == '0) begin
							state_q <= soc_pkg::ST_RES;
						end
					end
				end
				soc_pkg::ST_SHRD: state_q <= soc_pkg::ST_SHWR;
				soc_pkg::ST_SHWR: begin
					state_q <= (CW'(j_q) == pos_q) ? soc_pkg::ST_INS : soc_pkg::ST_SHRD;
				end
				soc_pkg::ST_INS: begin
					count_q <= count_q + 1'b1;
					state_q <= soc_pkg::ST_IDLE;
				end
				soc_pkg::ST_RES: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= soc_pkg::ST_IDLE;
					end
				end
				default: state_q <= soc_pkg::ST_IDLE;
			endcase
		end
	end

	assign res_ext = 32'(res_q);

	always_ff @(posedge clk) begin
		case (state_q)
			soc_pkg::ST_IDLE: begin
				if (accept) begin
					kind_q  <= s_tuser;
					key_q   <= $signed(s_tdata);
					lower_q <= 1'b0;
					lo_q    <= '0;
					hi_q    <= count_q;
					mid_q   <= half_cnt;
					pos_q   <= '0;
					res_q   <= '0;
				end
			end
			soc_pkg::ST_SRCH: begin
				if (more) begin
					lo_q  <= nlo;
					hi_q  <= nhi;
					mid_q <= nmid;
				end else if (kind_q == soc_pkg::KIND_LOAD) begin
					pos_q <= nlo;
					j_q   <= cnt_m1[AW-1:0];
				end else if (!lower_q) begin
					// upper bound found; lower bound lies in [0, upper]
					right_q <= nlo;
					res_q   <= '0;
					lower_q <= 1'b1;
					lo_q    <= '0;
					hi_q    <= nlo;
					mid_q   <= half_nlo;
				end else begin
					res_q <= right_q - nlo;
				end
			end
			soc_pkg::ST_SHWR: j_q <= j_q - 1'b1;
			soc_pkg::ST_RES: begin
				if (!m_tvalid_q || m_tready) begin
					m_data_q <= res_ext[soc_pkg::COUNT_W-1:0];
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(soc_pkg::OUT_TDATA_W - soc_pkg::COUNT_W){1'b0}}, m_data_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL)
		else $error("fill count above store depth");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == soc_pkg::ST_INS |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not grow the store");

	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == soc_pkg::ST_SHRD || state_q == soc_pkg::ST_SHWR) |->
		(CW'(j_q) >= pos_q && CW'(j_q) < count_q))
		else $error("shift index outside the moved range");

	a_search_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == soc_pkg::ST_SRCH |-> (lo_q <= mid_q && mid_q < hi_q && hi_q <= count_q))
		else $error("probe outside the search range");

endmodule

/* hdl/soc_ram.sv */
module soc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
